// File: src/keypad_debounce_repeat_longpress_core_macros.svh
// assertion macros for the keypad debounce core
`ifndef KEYPAD_DEBOUNCE_REPEAT_LONGPRESS_CORE_MACROS_SVH
`define KEYPAD_DEBOUNCE_REPEAT_LONGPRESS_CORE_MACROS_SVH

// same-cycle implication, off during reset
`define KDRL_ASSERT_IMP(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication, off during reset
`define KDRL_ASSERT_NXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// File: src/kdrl_pkg.sv
// shared types and constants for the keypad debounce core
package kdrl_pkg;

    localparam int BUTTONS = 10;
    localparam int FIELD_W = 10;
    localparam int TIME_W  = 32;
    localparam int CFG_W   = 16;
    localparam int CIDX_W  = 3;
    localparam int IDX_W   = (BUTTONS > 1) ? $clog2(BUTTONS) : 1;

    typedef logic [FIELD_W-1:0] t_field;
    typedef logic [TIME_W-1:0]  t_time;
    typedef logic [CFG_W-1:0]   t_cfg;
    typedef logic [IDX_W-1:0]   t_idx;

    // register indexes
    localparam logic [CIDX_W-1:0] REG_DEBOUNCE   = 3'd0;
    localparam logic [CIDX_W-1:0] REG_LONG_PRESS = 3'd1;
    localparam logic [CIDX_W-1:0] REG_REP_DELAY  = 3'd2;
    localparam logic [CIDX_W-1:0] REG_REP_RATE   = 3'd3;
    localparam logic [CIDX_W-1:0] REG_REP_MASK   = 3'd4;
    localparam logic [CIDX_W-1:0] REG_LONG_MASK  = 3'd5;

    // register reset values
    localparam t_cfg   DEF_DEBOUNCE   = 16'd50;
    localparam t_cfg   DEF_LONG_PRESS = 16'd1500;
    localparam t_cfg   DEF_REP_DELAY  = 16'd600;
    localparam t_cfg   DEF_REP_RATE   = 16'd150;
    localparam t_field DEF_REP_MASK   = 10'd3;
    localparam t_field DEF_LONG_MASK  = 10'd256;

    // per-button state word
    typedef struct packed {
        logic  last_raw;
        t_time settle_start;
        logic  held;
        t_time press_start;
        t_time next_repeat;
        logic  suppressed;
    } t_entry;

    localparam int ENTRY_W = $bits(t_entry);

endpackage

// File: src/keypad_debounce_repeat_longpress_core.sv
// keypad debounce with auto-repeat and long-press detection, top level
//
//  channel  direction  handshake                 payload
//  in       sink       i_in_valid / o_in_stall   i_raw_levels, i_now_ms
//  out      source     o_out_valid / i_out_stall o_click_pulses, o_long_press_pulses,
//                                                o_held_mask
//  cfg      sink       i_cfg_valid / o_cfg_ready i_cfg_index, i_cfg_data
//
//  a tick visits the state ram one button per cycle through its registered read,
//  and no new tick is accepted until the finished one leaves the done state
//  a tick is accepted while the previous result still waits in the output register
//  reset clears per-button valid flags at once, a never-written entry reads as zero
//  a stalled output holds the finished tick until the output register frees up
`include "keypad_debounce_repeat_longpress_core_macros.svh"

module keypad_debounce_repeat_longpress_core (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         i_in_valid,
    output logic                         o_in_stall,
    input  kdrl_pkg::t_field             i_raw_levels,
    input  kdrl_pkg::t_time              i_now_ms,
    output logic                         o_out_valid,
    input  logic                         i_out_stall,
    output kdrl_pkg::t_field             o_click_pulses,
    output kdrl_pkg::t_field             o_long_press_pulses,
    output kdrl_pkg::t_field             o_held_mask,
    input  logic                         i_cfg_valid,
    output logic                         o_cfg_ready,
    input  logic [kdrl_pkg::CIDX_W-1:0]  i_cfg_index,
    input  kdrl_pkg::t_cfg               i_cfg_data
);

    localparam logic [1:0] S_IDLE = 2'd0;
    localparam logic [1:0] S_RUN  = 2'd1;
    localparam logic [1:0] S_DONE = 2'd2;

    localparam kdrl_pkg::t_idx LAST_IDX = kdrl_pkg::t_idx'(kdrl_pkg::BUTTONS - 1);

    logic [1:0]       r_state, n_state;
    logic             r_issue, n_issue;
    kdrl_pkg::t_idx   r_rd_idx, n_rd_idx;
    logic             r_proc_vld, n_proc_vld;
    kdrl_pkg::t_idx   r_proc_idx, n_proc_idx;
    logic             r_rd_ok, n_rd_ok;
    logic [kdrl_pkg::BUTTONS-1:0] r_valid, n_valid;

    kdrl_pkg::t_field r_raw, n_raw;
    kdrl_pkg::t_time  r_now, n_now;
    kdrl_pkg::t_field r_acc_click, n_acc_click;
    kdrl_pkg::t_field r_acc_long, n_acc_long;
    kdrl_pkg::t_field r_acc_held, n_acc_held;

    logic             r_out_valid, n_out_valid;
    kdrl_pkg::t_field r_out_click, n_out_click;
    kdrl_pkg::t_field r_out_long, n_out_long;
    kdrl_pkg::t_field r_out_held, n_out_held;

    kdrl_pkg::t_cfg   r_debounce, n_debounce;
    kdrl_pkg::t_cfg   r_long_ms, n_long_ms;
    kdrl_pkg::t_cfg   r_rep_delay, n_rep_delay;
    kdrl_pkg::t_cfg   r_rep_rate, n_rep_rate;
    kdrl_pkg::t_field r_rep_mask, n_rep_mask;
    kdrl_pkg::t_field r_long_mask, n_long_mask;

    logic [kdrl_pkg::ENTRY_W-1:0] ram_rdata;
    logic [kdrl_pkg::ENTRY_W-1:0] ram_wdata;
    kdrl_pkg::t_entry cur_e, upd_e;
    kdrl_pkg::t_field bit_oh;
    logic             level, rep_en, long_en;
    logic             fire_click, fire_long;
    kdrl_pkg::t_time  settle_el, rep_diff, press_el;
    logic             in_acc, cfg_wr, out_load;

    kdrl_ram #(
        .WIDTH (kdrl_pkg::ENTRY_W),
        .DEPTH (kdrl_pkg::BUTTONS)
    ) u_state_ram (
        .i_clk   (i_clk),
        .i_we    (r_proc_vld),
        .i_waddr (r_proc_idx),
        .i_wdata (ram_wdata),
        .i_raddr (r_rd_idx),
        .o_rdata (ram_rdata)
    );

    assign in_acc      = i_in_valid && !o_in_stall;
    assign cfg_wr      = i_cfg_valid && o_cfg_ready;
    assign out_load    = (r_state == S_DONE) && (!r_out_valid || !i_out_stall);
    assign o_in_stall  = (r_state != S_IDLE);
    assign o_cfg_ready = 1'b1;

    // per-button update
    always_comb begin
        cur_e      = r_rd_ok ? kdrl_pkg::t_entry'(ram_rdata) : '0;
        bit_oh     = kdrl_pkg::t_field'(1) << r_proc_idx;
        level      = |(r_raw & bit_oh);
        rep_en     = |(r_rep_mask & bit_oh);
        long_en    = |(r_long_mask & bit_oh);
        fire_click = 1'b0;
        fire_long  = 1'b0;
        upd_e      = cur_e;
        if (level != cur_e.last_raw) begin
            upd_e.settle_start = r_now;
            upd_e.last_raw     = level;
        end
        settle_el = r_now - upd_e.settle_start;
        rep_diff  = r_now - upd_e.next_repeat;
        press_el  = r_now - upd_e.press_start;
        if (settle_el > kdrl_pkg::t_time'(r_debounce)) begin
            if (!level) begin
                if (!upd_e.held) begin
                    upd_e.held        = 1'b1;
                    upd_e.press_start = r_now;
                    upd_e.next_repeat = r_now + kdrl_pkg::t_time'(r_rep_delay);
                    upd_e.suppressed  = 1'b0;
                end else begin
                    if (rep_en && (rep_diff != '0) && !rep_diff[kdrl_pkg::TIME_W-1]) begin
                        fire_click        = 1'b1;
                        upd_e.next_repeat = r_now + kdrl_pkg::t_time'(r_rep_rate);
                        upd_e.suppressed  = 1'b1;
                    end
                    if (long_en && !upd_e.suppressed &&
                        (press_el > kdrl_pkg::t_time'(r_long_ms))) begin
                        fire_long        = 1'b1;
                        upd_e.suppressed = 1'b1;
                    end
                end
            end else if (upd_e.held) begin
                upd_e.held = 1'b0;
                if (!upd_e.suppressed) begin
                    fire_click = 1'b1;
                end
            end
        end
        ram_wdata = upd_e;
    end

    always_comb begin
        n_state     = r_state;
        n_issue     = r_issue;
        n_rd_idx    = r_rd_idx;
        n_proc_vld  = 1'b0;
        n_proc_idx  = r_proc_idx;
        n_rd_ok     = r_rd_ok;
        n_valid     = r_valid;
        n_raw       = r_raw;
        n_now       = r_now;
        n_acc_click = r_acc_click;
        n_acc_long  = r_acc_long;
        n_acc_held  = r_acc_held;
        n_out_valid = r_out_valid && i_out_stall;
        n_out_click = r_out_click;
        n_out_long  = r_out_long;
        n_out_held  = r_out_held;
        n_debounce  = r_debounce;
        n_long_ms   = r_long_ms;
        n_rep_delay = r_rep_delay;
        n_rep_rate  = r_rep_rate;
        n_rep_mask  = r_rep_mask;
        n_long_mask = r_long_mask;

        if (cfg_wr) begin
            case (i_cfg_index)
                kdrl_pkg::REG_DEBOUNCE:   n_debounce  = i_cfg_data;
                kdrl_pkg::REG_LONG_PRESS: n_long_ms   = i_cfg_data;
                kdrl_pkg::REG_REP_DELAY:  n_rep_delay = i_cfg_data;
                kdrl_pkg::REG_REP_RATE:   n_rep_rate  = i_cfg_data;
                kdrl_pkg::REG_REP_MASK:   n_rep_mask  = i_cfg_data[kdrl_pkg::FIELD_W-1:0];
                kdrl_pkg::REG_LONG_MASK:  n_long_mask = i_cfg_data[kdrl_pkg::FIELD_W-1:0];
                default: ;
            endcase
        end

        case (r_state)
            S_IDLE: begin
                if (in_acc) begin
                    n_raw       = i_raw_levels;
                    n_now       = i_now_ms;
                    n_acc_click = '0;
                    n_acc_long  = '0;
                    n_acc_held  = '0;
                    n_rd_idx    = '0;
                    n_issue     = 1'b1;
                    n_state     = S_RUN;
                end
            end
            S_RUN: begin
                if (r_issue) begin
                    n_proc_vld = 1'b1;
                    n_proc_idx = r_rd_idx;
                    n_rd_ok    = r_valid[r_rd_idx];
                    if (r_rd_idx == LAST_IDX) begin
                        n_issue = 1'b0;
                    end else begin
                        n_rd_idx = r_rd_idx + kdrl_pkg::t_idx'(1);
                    end
                end
                if (r_proc_vld) begin
                    n_valid[r_proc_idx] = 1'b1;
                    if (fire_click) begin
                        n_acc_click = r_acc_click | bit_oh;
                    end
                    if (fire_long) begin
                        n_acc_long = r_acc_long | bit_oh;
                    end
                    if (upd_e.held) begin
                        n_acc_held = r_acc_held | bit_oh;
                    end
                    if (r_proc_idx == LAST_IDX) begin
                        n_state = S_DONE;
                    end
                end
            end
            S_DONE: begin
                if (out_load) begin
                    n_out_valid = 1'b1;
                    n_out_click = r_acc_click;
                    n_out_long  = r_acc_long;
                    n_out_held  = r_acc_held;
                    n_state     = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_issue     <= 1'b0;
            r_rd_idx    <= '0;
            r_proc_vld  <= 1'b0;
            r_proc_idx  <= '0;
            r_rd_ok     <= 1'b0;
            r_valid     <= '0;
            r_out_valid <= 1'b0;
            r_debounce  <= kdrl_pkg::DEF_DEBOUNCE;
            r_long_ms   <= kdrl_pkg::DEF_LONG_PRESS;
            r_rep_delay <= kdrl_pkg::DEF_REP_DELAY;
            r_rep_rate  <= kdrl_pkg::DEF_REP_RATE;
            r_rep_mask  <= kdrl_pkg::DEF_REP_MASK;
            r_long_mask <= kdrl_pkg::DEF_LONG_MASK;
        end else begin
            r_state     <= n_state;
            r_issue     <= n_issue;
            r_rd_idx    <= n_rd_idx;
            r_proc_vld  <= n_proc_vld;
            r_proc_idx  <= n_proc_idx;
            r_rd_ok     <= n_rd_ok;
            r_valid     <= n_valid;
            r_out_valid <= n_out_valid;
            r_debounce  <= n_debounce;
            r_long_ms   <= n_long_ms;
            r_rep_delay <= n_rep_delay;
            r_rep_rate  <= n_rep_rate;
            r_rep_mask  <= n_rep_mask;
            r_long_mask <= n_long_mask;
        end
    end

    always_ff @(posedge i_clk) begin
        r_raw       <= n_raw;
        r_now       <= n_now;
        r_acc_click <= n_acc_click;
        r_acc_long  <= n_acc_long;
        r_acc_held  <= n_acc_held;
        r_out_click <= n_out_click;
        r_out_long  <= n_out_long;
        r_out_held  <= n_out_held;
    end

    assign o_out_valid         = r_out_valid;
    assign o_click_pulses      = r_out_click;
    assign o_long_press_pulses = r_out_long;
    assign o_held_mask         = r_out_held;

    `KDRL_ASSERT_IMP(a_proc_in_run, i_clk, i_rst_n, r_proc_vld || r_issue, r_state == S_RUN, "button visit outside run")
    `KDRL_ASSERT_NXT(a_done_loads, i_clk, i_rst_n, out_load, r_out_valid && r_state == S_IDLE, "finished tick not loaded")
    `KDRL_ASSERT_IMP(a_no_click_and_long, i_clk, i_rst_n, r_out_valid, (r_out_click & r_out_long) == '0, "click and long press on one button")
    `KDRL_ASSERT_NXT(a_last_visit_done, i_clk, i_rst_n, r_proc_vld && r_proc_idx == LAST_IDX, r_state == S_DONE && !r_issue, "run did not end after last button")

endmodule

// File: src/kdrl_ram.sv
// generic single-port-write, registered-read ram
module kdrl_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                                      i_clk,
    input  logic                                      i_we,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] i_waddr,
    input  logic [WIDTH-1:0]                          i_wdata,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] i_raddr,
    output logic [WIDTH-1:0]                          o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

// File: test/tb_keypad_debounce_repeat_longpress_core.sv
// testbench for the keypad debounce core with auto-repeat and long-press checking
`timescale 1ns / 1ps

module tb_keypad_debounce_repeat_longpress_core;

    localparam int CYCLE_LIMIT = 1000000;
    localparam int SETTLE_CYCLES = kdrl_pkg::BUTTONS + 8;
    localparam logic [kdrl_pkg::CIDX_W-1:0] REG_UNUSED_LO = 3'd6;
    localparam logic [kdrl_pkg::CIDX_W-1:0] REG_UNUSED_HI = 3'd7;

    typedef struct packed {
        kdrl_pkg::t_field click;
        kdrl_pkg::t_field long_press;
        kdrl_pkg::t_field held;
    } t_tick_result;

    logic                         i_clk = 1'b0;
    logic                         i_rst_n = 1'b0;
    logic                         i_in_valid = 1'b0;
    logic                         o_in_stall;
    kdrl_pkg::t_field             i_raw_levels = '0;
    kdrl_pkg::t_time              i_now_ms = '0;
    logic                         o_out_valid;
    logic                         i_out_stall = 1'b0;
    kdrl_pkg::t_field             o_click_pulses;
    kdrl_pkg::t_field             o_long_press_pulses;
    kdrl_pkg::t_field             o_held_mask;
    logic                         i_cfg_valid = 1'b0;
    logic                         o_cfg_ready;
    logic [kdrl_pkg::CIDX_W-1:0]  i_cfg_index = '0;
    kdrl_pkg::t_cfg               i_cfg_data = '0;

    keypad_debounce_repeat_longpress_core dut (
        .i_clk               (i_clk),
        .i_rst_n             (i_rst_n),
        .i_in_valid          (i_in_valid),
        .o_in_stall          (o_in_stall),
        .i_raw_levels        (i_raw_levels),
        .i_now_ms            (i_now_ms),
        .o_out_valid         (o_out_valid),
        .i_out_stall         (i_out_stall),
        .o_click_pulses      (o_click_pulses),
        .o_long_press_pulses (o_long_press_pulses),
        .o_held_mask         (o_held_mask),
        .i_cfg_valid         (i_cfg_valid),
        .o_cfg_ready         (o_cfg_ready),
        .i_cfg_index         (i_cfg_index),
        .i_cfg_data          (i_cfg_data)
    );

    always begin
        #1 i_clk = 1'b1;
        #1 i_clk = 1'b0;
    end

    // key timing settings as the block should hold them
    kdrl_pkg::t_cfg   cfg_debounce   = kdrl_pkg::DEF_DEBOUNCE;
    kdrl_pkg::t_cfg   cfg_long       = kdrl_pkg::DEF_LONG_PRESS;
    kdrl_pkg::t_cfg   cfg_rep_delay  = kdrl_pkg::DEF_REP_DELAY;
    kdrl_pkg::t_cfg   cfg_rep_rate   = kdrl_pkg::DEF_REP_RATE;
    kdrl_pkg::t_field cfg_rep_mask   = kdrl_pkg::DEF_REP_MASK;
    kdrl_pkg::t_field cfg_long_mask  = kdrl_pkg::DEF_LONG_MASK;

    // per-key debounce state
    logic             key_last_level [kdrl_pkg::BUTTONS];
    kdrl_pkg::t_time  key_settle_t   [kdrl_pkg::BUTTONS];
    logic             key_held       [kdrl_pkg::BUTTONS];
    kdrl_pkg::t_time  key_press_t    [kdrl_pkg::BUTTONS];
    kdrl_pkg::t_time  key_next_rep   [kdrl_pkg::BUTTONS];
    logic             key_quiet      [kdrl_pkg::BUTTONS];

    t_tick_result pending_results[$];
    int mismatch_count = 0;
    int cycle_count = 0;
    int send_idle_pct = 0;
    int recv_stall_pct = 0;
    int holdoff_req = 0;
    int holdoff_left = 0;

    kdrl_pkg::t_field pad_level = '1;
    kdrl_pkg::t_time  pad_now = '0;

    initial begin
        for (int b = 0; b < kdrl_pkg::BUTTONS; b++) begin
            key_last_level[b] = 1'b0;
            key_settle_t[b]   = '0;
            key_held[b]       = 1'b0;
            key_press_t[b]    = '0;
            key_next_rep[b]   = '0;
            key_quiet[b]      = 1'b0;
        end
    end

    function automatic t_tick_result debounce_tick(input kdrl_pkg::t_field raw,
                                                   input kdrl_pkg::t_time now);
        t_tick_result r;
        kdrl_pkg::t_time since_rep;
        logic lvl;
        r = '0;
        for (int b = 0; b < kdrl_pkg::BUTTONS; b++) begin
            lvl = raw[b];
            if (lvl != key_last_level[b]) begin
                key_settle_t[b] = now;
                key_last_level[b] = lvl;
            end
            if (kdrl_pkg::t_time'(now - key_settle_t[b]) >
                kdrl_pkg::t_time'(cfg_debounce)) begin
                if (!lvl) begin
                    if (!key_held[b]) begin
                        key_held[b] = 1'b1;
                        key_press_t[b] = now;
                        key_next_rep[b] = now + kdrl_pkg::t_time'(cfg_rep_delay);
                        key_quiet[b] = 1'b0;
                    end else begin
                        since_rep = now - key_next_rep[b];
                        if (cfg_rep_mask[b] && since_rep != '0 &&
                            !since_rep[kdrl_pkg::TIME_W-1]) begin
                            r.click[b] = 1'b1;
                            key_next_rep[b] = now + kdrl_pkg::t_time'(cfg_rep_rate);
                            key_quiet[b] = 1'b1;
                        end
                        if (cfg_long_mask[b] && !key_quiet[b] &&
                            kdrl_pkg::t_time'(now - key_press_t[b]) >
                            kdrl_pkg::t_time'(cfg_long)) begin
                            r.long_press[b] = 1'b1;
                            key_quiet[b] = 1'b1;
                        end
                    end
                end else if (key_held[b]) begin
                    key_held[b] = 1'b0;
                    if (!key_quiet[b])
                        r.click[b] = 1'b1;
                end
            end
            r.held[b] = key_held[b];
        end
        return r;
    endfunction

    always @(posedge i_clk) begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("simulation failed");
            $finish;
        end
    end

    always @(posedge i_clk) begin
        if (holdoff_req != 0) begin
            holdoff_left = holdoff_req;
            holdoff_req = 0;
        end
        if (holdoff_left != 0) begin
            holdoff_left--;
            i_out_stall <= 1'b1;
        end else begin
            i_out_stall <= ($urandom_range(99) < recv_stall_pct);
        end
    end

    always @(posedge i_clk) begin : check_results
        t_tick_result want;
        if (i_rst_n && o_out_valid && !i_out_stall) begin
            if (pending_results.size() == 0) begin
                $display("%0t unexpected result: click %h long %h held %h", $time,
                         o_click_pulses, o_long_press_pulses, o_held_mask);
                mismatch_count++;
            end else begin
                want = pending_results.pop_front();
                if (o_click_pulses !== want.click) begin
                    $display("%0t click_pulses expected %h actual %h", $time,
                             want.click, o_click_pulses);
                    mismatch_count++;
                end
                if (o_long_press_pulses !== want.long_press) begin
                    $display("%0t long_press_pulses expected %h actual %h", $time,
                             want.long_press, o_long_press_pulses);
                    mismatch_count++;
                end
                if (o_held_mask !== want.held) begin
                    $display("%0t held_mask expected %h actual %h", $time,
                             want.held, o_held_mask);
                    mismatch_count++;
                end
            end
        end
    end

    task automatic send_tick(input kdrl_pkg::t_field raw, input kdrl_pkg::t_time now);
        while ($urandom_range(99) < send_idle_pct) begin
            i_in_valid <= 1'b0;
            @(posedge i_clk);
        end
        i_in_valid   <= 1'b1;
        i_raw_levels <= raw;
        i_now_ms     <= now;
        pending_results.push_back(debounce_tick(raw, now));
        do @(posedge i_clk); while (o_in_stall);
    endtask

    task automatic drain();
        i_in_valid <= 1'b0;
        while (pending_results.size() != 0) @(posedge i_clk);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    task automatic write_reg(input logic [kdrl_pkg::CIDX_W-1:0] idx,
                             input kdrl_pkg::t_cfg data);
        i_cfg_valid <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= data;
        do @(posedge i_clk); while (!o_cfg_ready);
        case (idx)
            kdrl_pkg::REG_DEBOUNCE:   cfg_debounce  = data;
            kdrl_pkg::REG_LONG_PRESS: cfg_long      = data;
            kdrl_pkg::REG_REP_DELAY:  cfg_rep_delay = data;
            kdrl_pkg::REG_REP_RATE:   cfg_rep_rate  = data;
            kdrl_pkg::REG_REP_MASK:   cfg_rep_mask  = data[kdrl_pkg::FIELD_W-1:0];
            kdrl_pkg::REG_LONG_MASK:  cfg_long_mask = data[kdrl_pkg::FIELD_W-1:0];
            default: ;
        endcase
    endtask

    task automatic apply_config(input kdrl_pkg::t_cfg deb, input kdrl_pkg::t_cfg lp,
                                input kdrl_pkg::t_cfg rd, input kdrl_pkg::t_cfg rr,
                                input kdrl_pkg::t_cfg rm, input kdrl_pkg::t_cfg lm);
        write_reg(kdrl_pkg::REG_DEBOUNCE, deb);
        write_reg(kdrl_pkg::REG_LONG_PRESS, lp);
        write_reg(kdrl_pkg::REG_REP_DELAY, rd);
        write_reg(kdrl_pkg::REG_REP_RATE, rr);
        write_reg(kdrl_pkg::REG_REP_MASK, rm);
        write_reg(kdrl_pkg::REG_LONG_MASK, lm);
        i_cfg_valid <= 1'b0;
    endtask

    // held and released keys with occasional bounce and time jumps
    task automatic key_activity(input int n, input int max_step, input int flip_pct);
        kdrl_pkg::t_field raw;
        int roll;
        for (int k = 0; k < n; k++) begin
            for (int b = 0; b < kdrl_pkg::BUTTONS; b++)
                if ($urandom_range(99) < flip_pct)
                    pad_level[b] = ~pad_level[b];
            raw = pad_level;
            if ($urandom_range(99) < 8)
                raw = raw ^ kdrl_pkg::t_field'($urandom);
            roll = $urandom_range(99);
            if (roll < 2)
                pad_now = $urandom;
            else if (roll >= 5)
                pad_now = pad_now + kdrl_pkg::t_time'($urandom_range(max_step, 1));
            send_tick(raw, pad_now);
        end
    endtask

    task automatic test_directed();
        send_idle_pct = 0;
        recv_stall_pct = 0;
        send_tick(10'h3FF, 32'd0);
        send_tick(10'h3FF, 32'd51);
        send_tick(10'h000, 32'd60);
        send_tick(10'h000, 32'd111);
        send_tick(10'h000, 32'd712);
        send_tick(10'h000, 32'd862);
        send_tick(10'h000, 32'd863);
        send_tick(10'h000, 32'd1611);
        send_tick(10'h000, 32'd1612);
        send_tick(10'h2AA, 32'd1700);
        send_tick(10'h000, 32'd1710);
        send_tick(10'h3FF, 32'd1800);
        send_tick(10'h3FF, 32'd1850);
        send_tick(10'h3FF, 32'd1851);
        send_tick(10'h000, 32'hFFFF_FFC0);
        send_tick(10'h000, 32'hFFFF_FFFF);
        send_tick(10'h155, 32'h0000_0040);
        send_tick(10'h3FF, 32'h0000_0080);
        send_tick(10'h3FF, 32'h0000_00C0);
        drain();
    endtask

    task automatic test_zero_timing();
        apply_config(16'h0000, 16'h0000, 16'h0000, 16'h0000, 16'hFFFF, 16'hFFFF);
        send_idle_pct = 0;
        recv_stall_pct = 0;
        pad_now = $urandom;
        key_activity(150, 3, 30);
        drain();
    endtask

    task automatic test_default_timing();
        apply_config(kdrl_pkg::DEF_DEBOUNCE, kdrl_pkg::DEF_LONG_PRESS,
                     kdrl_pkg::DEF_REP_DELAY, kdrl_pkg::DEF_REP_RATE,
                     16'hFC03, 16'h0302);
        send_idle_pct = 87;
        recv_stall_pct = 0;
        key_activity(300, 60, 3);
        drain();
    endtask

    task automatic test_max_timing();
        apply_config(16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF, 16'h0000, 16'h03FF);
        send_idle_pct = 0;
        recv_stall_pct = 87;
        key_activity(100, 20000, 10);
        drain();
        apply_config(16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF, 16'h03FF, 16'h0000);
        key_activity(100, 20000, 10);
        drain();
    endtask

    task automatic test_random_config();
        int span;
        for (int p = 0; p < 4; p++) begin
            case ($urandom_range(2))
                0: span = 30;
                1: span = 2000;
                default: span = 65535;
            endcase
            apply_config(kdrl_pkg::t_cfg'($urandom_range(span)),
                         kdrl_pkg::t_cfg'($urandom_range(span)),
                         kdrl_pkg::t_cfg'($urandom_range(span)),
                         kdrl_pkg::t_cfg'($urandom_range(span)),
                         kdrl_pkg::t_cfg'($urandom), kdrl_pkg::t_cfg'($urandom));
            send_idle_pct = 7;
            recv_stall_pct = 7;
            key_activity(100, span / 8 + 1, 5);
            drain();
        end
    endtask

    task automatic test_time_wrap();
        apply_config(16'd20, 16'd300, 16'd100, 16'd30, 16'h02F5, 16'h03CF);
        send_idle_pct = 0;
        recv_stall_pct = 0;
        pad_now = 32'hFFFF_F800;
        key_activity(150, 40, 6);
        drain();
    endtask

    task automatic test_unused_index();
        write_reg(REG_UNUSED_LO, 16'h0000);
        write_reg(REG_UNUSED_HI, 16'hFFFF);
        i_cfg_valid <= 1'b0;
        key_activity(20, 40, 6);
        drain();
    endtask

    task automatic test_output_holdoff();
        send_idle_pct = 0;
        recv_stall_pct = 0;
        holdoff_req = 600;
        key_activity(80, 40, 6);
        drain();
    endtask

    initial begin
        repeat (10) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);
        test_directed();
        test_zero_timing();
        test_default_timing();
        test_max_timing();
        test_random_config();
        test_time_wrap();
        test_unused_index();
        test_output_holdoff();
        repeat (SETTLE_CYCLES) @(posedge i_clk);
        if (mismatch_count == 0 && pending_results.size() == 0) begin
            $display("simulation ok");
        end else begin
            $display("simulation failed");
        end
        $finish;
    end

endmodule
